FILE: hw/rtl/qef_accumulate_and_error_top_assert.svh
// ----------------------------------------------------------------------------
// QEF accumulator assertion macros
// Concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QEF_ACCUMULATE_AND_ERROR_TOP_ASSERT_SVH
`define QEF_ACCUMULATE_AND_ERROR_TOP_ASSERT_SVH
`ifndef SYNTH
`define QEF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qef: assertion failed");
`define QEF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qef: assertion failed");
`else
`define QEF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define QEF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/qef_pkg.sv
// ----------------------------------------------------------------------------
// QEF accumulator package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package qef_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 16;

   localparam int NORM_W  = 16;
   localparam int MUL_W   = 64;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DIGIT_W = 8;
   localparam int DIGITS  = MUL_W / DIGIT_W;
   localparam int UNIT_W  = 15;
   localparam logic [UNIT_W-1:0] UNIT_ONE = 15'd16384;
   localparam logic [3:0] TOP_BIT   = 4'(UNIT_W - 1);
   localparam logic [2:0] LAST_AXIS = 3'd2;
   localparam logic [2:0] LAST_PAIR = 3'd5;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_EVAL  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_SAT    = 2'd2
   } status_type;

   // multiply-based datapath operations
   typedef enum logic [3:0] {
      OP_LEN,   // len2 += n*n
      OP_TGT,   // target = n*n << 30
      OP_TSQ,   // t = 2*trial-1, t*t
      OP_TCMP,  // t*t*len2 <= target
      OP_NP,    // normal products
      OP_D,     // d += u*p
      OP_WO,    // offsets += d*u
      OP_RS,    // residual += d*d
      OP_PP,    // position product
      OP_EA,    // error += np*pp
      OP_EW     // error += wo*(-2p)
   } op_type;

   typedef struct packed {
      logic       load;
      logic       start;
      op_type     op;
      logic [2:0] idx;
      logic [3:0] bitpos;
      logic       reject;
      logic       commit;
      logic       clear;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic len_zero;
   } stat_type;

endpackage

FILE: hw/rtl/qef_mul.sv
// ----------------------------------------------------------------------------
// QEF shared multiplier
// Signed 64x64 multiply, one 8-bit digit of b per cycle, sign fixed at end.
// ----------------------------------------------------------------------------
module qef_mul import qef_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [MUL_W-1:0]  a,
   input  logic signed [MUL_W-1:0]  b,
   output logic                     done,
   output logic signed [PROD_W-1:0] prod
);

   localparam int CNT_W = $clog2(DIGITS);
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

   logic                     busy_ff, busy_in, fix_ff, fix_in, done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [MUL_W-1:0]         mag_a_ff, mag_a_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] res_ff, res_in;
   logic [MUL_W+DIGIT_W-1:0] pd, sum;
   logic [MUL_W-1:0]         abs_a, abs_b;

   assign abs_a = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
   assign abs_b = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
   assign pd    = mag_a_ff * acc_ff[DIGIT_W-1:0];
   assign sum   = {{DIGIT_W{1'b0}}, acc_ff[PROD_W-1:MUL_W]} + pd;

   always_comb begin
      busy_in  = busy_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mag_a_in = mag_a_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      if (start) begin
         mag_a_in = abs_a;
         acc_in   = {{MUL_W{1'b0}}, abs_b};
         neg_in   = a[MUL_W-1] ^ b[MUL_W-1];
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MUL_W-1:DIGIT_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_DIGIT) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         res_in  = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      mag_a_ff <= mag_a_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
   end

   assign done = done_ff;
   assign prod = res_ff;

endmodule

FILE: hw/rtl/qef_dp.sv
// ----------------------------------------------------------------------------
// QEF datapath
// Operand registers, accumulators, result register and the shared multiplier.
// ----------------------------------------------------------------------------
`include "qef_accumulate_and_error_top_assert.svh"

module qef_dp import qef_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic [1:0]         rsp_status,
   output logic signed [63:0] rsp_error_value,
   output logic [15:0]        rsp_point_count,
   output logic signed [31:0] rsp_mass_sum_x,
   output logic signed [31:0] rsp_mass_sum_y,
   output logic signed [31:0] rsp_mass_sum_z
);

   localparam int TGT_W = 61;
   localparam logic signed [47:0] NP_MAX  = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] NP_MIN  = {1'b1, {47{1'b0}}};
   localparam logic signed [63:0] W64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] W64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [31:0] W32_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] W32_MIN = {1'b1, {31{1'b0}}};

   function automatic logic signed [COORD_BITS-1:0] pos_of(input logic [15:0] v);
      return COORD_BITS'(v);
   endfunction

   function automatic logic [1:0] pair_i(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_j(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0:       r = 2'd0;
         3'd1, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [47:0] acc,
                                                input logic signed [47:0] add);
      logic signed [48:0] s;
      s = 49'(acc) + 49'(add);
      if (s[48] != s[47]) return s[48] ? NP_MIN : NP_MAX;
      return s[47:0];
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [63:0] acc,
                                                input logic signed [63:0] add);
      logic signed [64:0] s;
      s = 65'(acc) + 65'(add);
      if (s[64] != s[63]) return s[64] ? W64_MIN : W64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [31:0] acc,
                                                input logic signed [COORD_BITS-1:0] add);
      logic signed [32:0] s;
      s = 33'(acc) + 33'(add);
      if (s[32] != s[31]) return s[32] ? W32_MIN : W32_MAX;
      return s[31:0];
   endfunction

   function automatic logic signed [63:0] clip(input logic signed [PROD_W-1:0] v);
      if ((&v[PROD_W-1:63]) || !(|v[PROD_W-1:63])) return v[63:0];
      return v[PROD_W-1] ? W64_MIN : W64_MAX;
   endfunction

   // item operands
   mode_type                     mode_ff, mode_in;
   logic signed [COORD_BITS-1:0] p_ff [3], p_in [3];
   logic signed [NORM_W-1:0]     n_ff [3], n_in [3];
   // normalization
   logic [31:0]                  len2_ff, len2_in;
   logic [TGT_W-1:0]             tgt_ff, tgt_in;
   logic [UNIT_W-1:0]            q_ff, q_in, trial_ff, trial_in;
   logic signed [NORM_W-1:0]     u_ff [3], u_in [3];
   logic signed [MUL_W-1:0]      tmp_ff, tmp_in, d_ff, d_in;
   // accumulators
   logic signed [47:0]           np_ff [6], np_in [6];
   logic signed [63:0]           wo_ff [3], wo_in [3];
   logic signed [63:0]           rs_ff, rs_in;
   logic signed [31:0]           ps_ff [3], ps_in [3];
   logic [COUNT_BITS-1:0]        cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]     eacc_ff, eacc_in;
   status_type                   status_ff, status_in;
   op_type                       wop_ff, wop_in;
   logic [2:0]                   widx_ff, widx_in;
   // result register
   logic [1:0]                   st_out_ff, st_out_in;
   logic signed [63:0]           err_out_ff, err_out_in;
   logic [15:0]                  cnt_out_ff, cnt_out_in;
   logic signed [31:0]           ps_out_ff [3], ps_out_in [3];

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     mul_done;
   logic signed [PROD_W-1:0] prod;
   logic [1:0]               ax, pi, pj, wax, wpi, wpj;
   logic [UNIT_W-1:0]        trial_c, q_new;
   logic [UNIT_W:0]          tsq;
   logic                     cmp_ok;

   qef_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   assign ax      = cmd.idx[1:0];
   assign pi      = pair_i(cmd.idx);
   assign pj      = pair_j(cmd.idx);
   assign wax     = widx_ff[1:0];
   assign wpi     = pair_i(widx_ff);
   assign wpj     = pair_j(widx_ff);
   assign trial_c = q_ff | (UNIT_W'(1) << cmd.bitpos);
   assign tsq     = {trial_c, 1'b0} - 1'b1;
   assign cmp_ok  = ($unsigned(prod) <= PROD_W'(tgt_ff)) && (trial_ff <= UNIT_ONE);
   assign q_new   = cmp_ok ? trial_ff : q_ff;

   // operand select at issue
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LEN, OP_TGT: begin
            mul_a = MUL_W'(n_ff[ax]);
            mul_b = MUL_W'(n_ff[ax]);
         end
         OP_TSQ: begin
            mul_a = $signed(MUL_W'(tsq));
            mul_b = $signed(MUL_W'(tsq));
         end
         OP_TCMP: begin
            mul_a = tmp_ff;
            mul_b = $signed(MUL_W'(len2_ff));
         end
         OP_NP: begin
            mul_a = MUL_W'(u_ff[pi]);
            mul_b = MUL_W'(u_ff[pj]);
         end
         OP_D: begin
            mul_a = MUL_W'(u_ff[ax]);
            mul_b = MUL_W'(p_ff[ax]);
         end
         OP_WO: begin
            mul_a = d_ff;
            mul_b = MUL_W'(u_ff[ax]);
         end
         OP_RS: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         OP_PP: begin
            mul_a = MUL_W'(p_ff[pi]);
            mul_b = MUL_W'(p_ff[pj]);
         end
         OP_EA: begin
            mul_a = MUL_W'(np_ff[cmd.idx]);
            mul_b = tmp_ff;
         end
         OP_EW: begin
            mul_a = wo_ff[ax];
            mul_b = -(MUL_W'(p_ff[ax]) <<< 1);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      len2_in    = len2_ff;
      tgt_in     = tgt_ff;
      q_in       = q_ff;
      trial_in   = trial_ff;
      u_in       = u_ff;
      tmp_in     = tmp_ff;
      d_in       = d_ff;
      np_in      = np_ff;
      wo_in      = wo_ff;
      rs_in      = rs_ff;
      ps_in      = ps_ff;
      cnt_in     = cnt_ff;
      eacc_in    = eacc_ff;
      status_in  = status_ff;
      wop_in     = wop_ff;
      widx_in    = widx_ff;
      st_out_in  = st_out_ff;
      err_out_in = err_out_ff;
      cnt_out_in = cnt_out_ff;
      ps_out_in  = ps_out_ff;

      if (cmd.load) begin
         mode_in   = mode_type'(req_mode);
         p_in[0]   = pos_of($unsigned(req_pos_x));
         p_in[1]   = pos_of($unsigned(req_pos_y));
         p_in[2]   = pos_of($unsigned(req_pos_z));
         n_in[0]   = req_normal_x;
         n_in[1]   = req_normal_y;
         n_in[2]   = req_normal_z;
         status_in = STAT_OK;
         eacc_in   = PROD_W'(rs_ff);
      end

      if (cmd.start) begin
         wop_in  = cmd.op;
         widx_in = cmd.idx;
         if (cmd.op == OP_TSQ) trial_in = trial_c;
      end

      if (mul_done) begin
         case (wop_ff)
            OP_LEN:  len2_in = ((widx_ff == 3'd0) ? 32'd0 : len2_ff) + prod[31:0];
            OP_TGT: begin
               tgt_in = {prod[30:0], 30'd0};
               q_in   = '0;
            end
            OP_TSQ:  tmp_in = $signed(prod[MUL_W-1:0]);
            OP_TCMP: begin
               q_in = q_new;
               u_in[wax] = n_ff[wax][NORM_W-1] ? -$signed({1'b0, q_new})
                                               : $signed({1'b0, q_new});
            end
            OP_NP:   np_in[widx_ff] = sat48(np_ff[widx_ff], $signed(prod[47:0]));
            OP_D:    d_in = ((widx_ff == 3'd0) ? '0 : d_ff) + $signed(prod[MUL_W-1:0]);
            OP_WO:   wo_in[wax] = sat64(wo_ff[wax], $signed(prod[63:0]));
            OP_RS:   rs_in = sat64(rs_ff, clip(prod));
            OP_PP: begin
               if (wpi != wpj) tmp_in = $signed({prod[MUL_W-2:0], 1'b0});
               else            tmp_in = $signed(prod[MUL_W-1:0]);
            end
            OP_EA, OP_EW: eacc_in = eacc_ff + prod;
            default: ;
         endcase
      end

      if (cmd.reject) status_in = STAT_REJECT;

      if (cmd.commit) begin
         for (int i = 0; i < 3; i++) ps_in[i] = sat32(ps_ff[i], p_ff[i]);
         if (&cnt_ff) status_in = STAT_SAT;
         else         cnt_in    = cnt_ff + 1'b1;
      end

      if (cmd.clear) begin
         for (int i = 0; i < 6; i++) np_in[i] = '0;
         for (int i = 0; i < 3; i++) begin
            wo_in[i] = '0;
            ps_in[i] = '0;
         end
         rs_in  = '0;
         cnt_in = '0;
      end

      if (cmd.emit) begin
         st_out_in  = status_ff;
         err_out_in = (mode_ff == MODE_EVAL) ? clip(eacc_ff) : '0;
         cnt_out_in = 16'(cnt_ff);
         ps_out_in  = ps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) np_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            wo_ff[i] <= '0;
            ps_ff[i] <= '0;
         end
         rs_ff  <= '0;
         cnt_ff <= '0;
         q_ff   <= '0;
      end else begin
         np_ff  <= np_in;
         wo_ff  <= wo_in;
         ps_ff  <= ps_in;
         rs_ff  <= rs_in;
         cnt_ff <= cnt_in;
         q_ff   <= q_in;
      end
      mode_ff    <= mode_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      len2_ff    <= len2_in;
      tgt_ff     <= tgt_in;
      trial_ff   <= trial_in;
      u_ff       <= u_in;
      tmp_ff     <= tmp_in;
      d_ff       <= d_in;
      eacc_ff    <= eacc_in;
      status_ff  <= status_in;
      wop_ff     <= wop_in;
      widx_ff    <= widx_in;
      st_out_ff  <= st_out_in;
      err_out_ff <= err_out_in;
      cnt_out_ff <= cnt_out_in;
      ps_out_ff  <= ps_out_in;
   end

   assign stat.mul_done = mul_done;
   assign stat.len_zero = (len2_ff == 32'd0);

   assign rsp_status      = st_out_ff;
   assign rsp_error_value = err_out_ff;
   assign rsp_point_count = cnt_out_ff;
   assign rsp_mass_sum_x  = ps_out_ff[0];
   assign rsp_mass_sum_y  = ps_out_ff[1];
   assign rsp_mass_sum_z  = ps_out_ff[2];

   // unit component search never passes one
   `QEF_ASSERT_IMPLIES(a_unit_bound, clock, reset, 1'b1, q_ff <= UNIT_ONE)

endmodule

FILE: hw/rtl/qef_ctrl.sv
// ----------------------------------------------------------------------------
// QEF controller
// Sequences datapath operations for each item and owns the handshakes.
// ----------------------------------------------------------------------------
`include "qef_accumulate_and_error_top_assert.svh"

module qef_ctrl import qef_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  stat_type   stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_CHECK,
      S_COMMIT,
      S_CLEAR,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic [2:0] idx_ff, idx_in;
   logic [3:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.idx      = idx_ff;
      cmd.bitpos   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = 3'd0;
               case (mode_type'(req_mode))
                  MODE_ADD: begin
                     op_in    = OP_LEN;
                     state_in = S_ISSUE;
                  end
                  MODE_EVAL: begin
                     op_in    = OP_PP;
                     state_in = S_ISSUE;
                  end
                  MODE_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_EMIT;
               endcase
            end
         end
         S_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (stat.mul_done) begin
               state_in = S_ISSUE;
               case (op_ff)
                  OP_LEN: begin
                     if (idx_ff == LAST_AXIS) state_in = S_CHECK;
                     else                     idx_in   = idx_ff + 1'b1;
                  end
                  OP_TGT: begin
                     op_in  = OP_TSQ;
                     bit_in = TOP_BIT;
                  end
                  OP_TSQ: op_in = OP_TCMP;
                  OP_TCMP: begin
                     if (bit_ff != 4'd0) begin
                        bit_in = bit_ff - 1'b1;
                        op_in  = OP_TSQ;
                     end else if (idx_ff != LAST_AXIS) begin
                        idx_in = idx_ff + 1'b1;
                        op_in  = OP_TGT;
                     end else begin
                        idx_in = 3'd0;
                        op_in  = OP_NP;
                     end
                  end
                  OP_NP: begin
                     if (idx_ff != LAST_PAIR) idx_in = idx_ff + 1'b1;
                     else begin
                        idx_in = 3'd0;
                        op_in  = OP_D;
                     end
                  end
                  OP_D: begin
                     if (idx_ff != LAST_AXIS) idx_in = idx_ff + 1'b1;
                     else begin
                        idx_in = 3'd0;
                        op_in  = OP_WO;
                     end
                  end
                  OP_WO: begin
                     if (idx_ff != LAST_AXIS) idx_in = idx_ff + 1'b1;
                     else                     op_in  = OP_RS;
                  end
                  OP_RS: state_in = S_COMMIT;
                  OP_PP: op_in = OP_EA;
                  OP_EA: begin
                     if (idx_ff != LAST_PAIR) begin
                        idx_in = idx_ff + 1'b1;
                        op_in  = OP_PP;
                     end else begin
                        idx_in = 3'd0;
                        op_in  = OP_EW;
                     end
                  end
                  OP_EW: begin
                     if (idx_ff != LAST_AXIS) idx_in   = idx_ff + 1'b1;
                     else                     state_in = S_EMIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHECK: begin
            if (stat.len_zero) begin
               cmd.reject = 1'b1;
               state_in   = S_EMIT;
            end else begin
               idx_in   = 3'd0;
               op_in    = OP_TGT;
               state_in = S_ISSUE;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_EMIT;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_LEN;
         idx_ff       <= 3'd0;
         bit_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `QEF_ASSERT_IMPLIES(a_done_in_wait, clock, reset, stat.mul_done, state_ff == S_WAIT)
   `QEF_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   `QEF_ASSERT_NEXT(a_single_start, clock, reset, cmd.start, !cmd.start && state_ff == S_WAIT)

endmodule

FILE: hw/rtl/qef_accumulate_and_error_top.sv
// ----------------------------------------------------------------------------
// QEF accumulate and error top level
// Quadric error function accumulator: adds samples, evaluates E(x), clears.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | mode, pos_x/y/z, normal_x/y/z
//  rsp     | out       | rsp_valid / rsp_stall | status, error_value,
//          |           |                       | point_count, mass_sum_x/y/z
//
// One item at a time. Each multiply goes through the single shared 64x64
// digit-serial multiplier. Add sample: 109 multiplies (the unit-normal search
// dominates); a zero normal is rejected after its 3 length multiplies.
// Evaluate: 15 multiplies. Clear: no multiplies.
// Synchronous reset clears the accumulators and control at once; no sweep.
// The result sits in an output register, so a new item is taken while a
// stalled result waits; only the next emit waits on rsp_stall.
// ----------------------------------------------------------------------------
module qef_accumulate_and_error_top import qef_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [63:0] rsp_error_value,
   output logic [15:0]        rsp_point_count,
   output logic signed [31:0] rsp_mass_sum_x,
   output logic signed [31:0] rsp_mass_sum_y,
   output logic signed [31:0] rsp_mass_sum_z
);

   cmd_type  cmd;    // controller -> datapath
   stat_type stat;   // datapath -> controller

   // sequencer: handshakes plus the per-item operation schedule
   qef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // operands, accumulators, shared multiplier and result register
   qef_dp #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .rsp_status      (rsp_status),
      .rsp_error_value (rsp_error_value),
      .rsp_point_count (rsp_point_count),
      .rsp_mass_sum_x  (rsp_mass_sum_x),
      .rsp_mass_sum_y  (rsp_mass_sum_y),
      .rsp_mass_sum_z  (rsp_mass_sum_z)
   );

endmodule
